[rtl/core/ucwe_pkg.sv]
package ucwe_pkg;

    localparam int CHAR_W = 24;
    localparam int CFG_IDX_W = 1;
    localparam int SLOTS = 4;
    localparam int SLOT_CNT_W = $clog2(SLOTS + 1);

    localparam logic [CFG_IDX_W-1:0] REG_START_CHAR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAKE_CHARS = 1'd1;

    localparam logic [1:0] PH_START   = 2'd0;
    localparam logic [1:0] PH_HELD_EF = 2'd1;
    localparam logic [1:0] PH_HELD_BB = 2'd2;
    localparam logic [1:0] PH_BODY    = 2'd3;

    localparam logic [7:0] BOM_0 = 8'hef;
    localparam logic [7:0] BOM_1 = 8'hbb;
    localparam logic [7:0] BOM_2 = 8'hbf;

    localparam logic [CHAR_W-1:0] CHAR_MAX = {CHAR_W{1'b1}};

    typedef struct packed {
        logic [2:0]        skip_left;
        logic              in_window;
        logic [CHAR_W-1:0] char_index;
        logic [CHAR_W-1:0] take_left;
        logic              halted;
    } body_st_t;

    typedef struct packed {
        body_st_t st;
        logic     emit;
    } body_res_t;

    typedef struct packed {
        logic [7:0]        byte_out;
        logic              byte_valid;
        logic              string_done;
        logic [CHAR_W-1:0] char_total;
    } result_t;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        priority if ((b & 8'h80) == 8'h00) len = 3'd1;
        else if ((b & 8'he0) == 8'hc0) len = 3'd2;
        else if ((b & 8'hf0) == 8'he0) len = 3'd3;
        else if ((b & 8'hf8) == 8'hf0) len = 3'd4;
        else if ((b & 8'hfc) == 8'hf8) len = 3'd5;
        else if ((b & 8'hfe) == 8'hfc) len = 3'd6;
        else len = 3'd0;
        return len;
    endfunction

    function automatic body_res_t body_step(input body_st_t st, input logic [7:0] b,
                                            input logic [CHAR_W-1:0] start,
                                            input logic en);
        body_res_t  r;
        logic [2:0] len;
        logic       iw;
        r.st   = st;
        r.emit = 1'b0;
        len    = lead_length(b);
        iw     = (st.char_index >= start) && (st.take_left != '0);
        if (en && !st.halted) begin
            if (st.skip_left != 3'd0) begin
                r.st.skip_left = st.skip_left - 3'd1;
                r.emit = st.in_window;
            end else if (len == 3'd0) begin
                r.st.halted = 1'b1;
                r.st.in_window = 1'b0;
            end else begin
                r.st.in_window = iw;
                if (iw) begin
                    r.st.take_left = st.take_left - CHAR_W'(1);
                end
                if (st.char_index != CHAR_MAX) begin
                    r.st.char_index = st.char_index + CHAR_W'(1);
                end
                r.st.skip_left = len - 3'd1;
                r.emit = iw;
            end
        end
        return r;
    endfunction

endpackage

[rtl/core/utf8_char_window_extractor.sv]
// Channel | Direction | Ports                                      | Word
// s_      | in        | s_byte_in, s_end_of_string                 | one string byte
// m_      | out       | m_byte_out, m_byte_valid, m_string_done,   | one result
//         |           | m_char_total                               |
// cfg     | in        | cfg_we, cfg_index, cfg_wdata               | one register
//
// One input word per cycle while results drain; each yields up to four
// results, which leave a four-entry result buffer one per cycle on m_ready.
// Results beyond one per word arise only at string start (mark replay) and
// at string end (final result). A one-word input register takes a word while
// a result waits. Synchronous active-low reset clears all control state.
module utf8_char_window_extractor
    import ucwe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CHAR_W-1:0]    cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_byte_in,
    input  logic                 s_end_of_string,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_byte_out,
    output logic                 m_byte_valid,
    output logic                 m_string_done,
    output logic [CHAR_W-1:0]    m_char_total
);

    logic [CHAR_W-1:0]     start_char_reg;
    logic [CHAR_W-1:0]     take_chars_reg;

    logic                  a_valid_reg;
    logic [7:0]            a_byte_reg;
    logic                  a_eos_reg;
    logic                  a_take;

    logic [1:0]            mark_phase_reg, mark_phase_next;
    logic [7:0]            held_bytes_reg [2];
    logic [7:0]            held_bytes_next [2];
    body_st_t              body_reg, body_next;

    result_t               slot_reg [SLOTS];
    result_t               slot_next [SLOTS];
    logic [SLOT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  pop;

    assign pop     = (cnt_reg != '0) && m_ready;
    assign a_take  = a_valid_reg && ((cnt_reg == '0) ||
                     ((cnt_reg == SLOT_CNT_W'(1)) && m_ready));
    assign s_ready = !a_valid_reg || a_take;

    assign m_valid       = cnt_reg != '0;
    assign m_byte_out    = slot_reg[0].byte_out;
    assign m_byte_valid  = slot_reg[0].byte_valid;
    assign m_string_done = slot_reg[0].string_done;
    assign m_char_total  = slot_reg[0].char_total;

    always_comb begin
        body_st_t              s0;
        body_res_t             r0, r1, r2;
        logic [7:0]            p0, p1, p2;
        logic                  e0, e1, e2;
        result_t               cand [SLOTS];
        logic                  cv [SLOTS];
        logic [SLOT_CNT_W-1:0] k;

        s0 = body_reg;
        held_bytes_next[0] = held_bytes_reg[0];
        held_bytes_next[1] = held_bytes_reg[1];
        if (mark_phase_reg == PH_START) begin
            s0.skip_left  = 3'd0;
            s0.in_window  = 1'b0;
            s0.char_index = '0;
            s0.take_left  = take_chars_reg;
            s0.halted     = 1'b0;
        end

        p0 = a_byte_reg;
        p1 = a_byte_reg;
        p2 = a_byte_reg;
        e0 = 1'b0;
        e1 = 1'b0;
        e2 = 1'b0;
        mark_phase_next = PH_BODY;
        unique case (mark_phase_reg)
            PH_START: begin
                if (a_byte_reg == BOM_0 && !a_eos_reg) begin
                    held_bytes_next[0] = a_byte_reg;
                    mark_phase_next = PH_HELD_EF;
                end else begin
                    e2 = 1'b1;
                end
            end
            PH_HELD_EF: begin
                if (a_byte_reg == BOM_1 && !a_eos_reg) begin
                    held_bytes_next[1] = a_byte_reg;
                    mark_phase_next = PH_HELD_BB;
                end else begin
                    p1 = held_bytes_reg[0];
                    e1 = 1'b1;
                    e2 = 1'b1;
                end
            end
            PH_HELD_BB: begin
                if (a_byte_reg != BOM_2) begin
                    p0 = held_bytes_reg[0];
                    p1 = held_bytes_reg[1];
                    e0 = 1'b1;
                    e1 = 1'b1;
                    e2 = 1'b1;
                end
            end
            default: begin
                e2 = 1'b1;
            end
        endcase
        if (a_eos_reg) begin
            mark_phase_next = PH_START;
        end

        r0 = body_step(s0, p0, start_char_reg, e0);
        r1 = body_step(r0.st, p1, start_char_reg, e1);
        r2 = body_step(r1.st, p2, start_char_reg, e2);
        body_next = r2.st;

        cand[0] = '{byte_out: p0, byte_valid: 1'b1, string_done: 1'b0,
                    char_total: r0.st.char_index};
        cand[1] = '{byte_out: p1, byte_valid: 1'b1, string_done: 1'b0,
                    char_total: r1.st.char_index};
        cand[2] = '{byte_out: p2, byte_valid: 1'b1, string_done: 1'b0,
                    char_total: r2.st.char_index};
        cand[3] = '{byte_out: 8'h00, byte_valid: 1'b0, string_done: 1'b1,
                    char_total: r2.st.char_index};
        cv[0] = r0.emit;
        cv[1] = r1.emit;
        cv[2] = r2.emit;
        cv[3] = a_eos_reg;

        for (int i = 0; i < SLOTS; i++) begin
            slot_next[i] = slot_reg[i];
        end
        cnt_next = cnt_reg;
        if (a_take) begin
            k = '0;
            for (int i = 0; i < SLOTS; i++) begin
                if (cv[i]) begin
                    slot_next[k[1:0]] = cand[i];
                    k = k + SLOT_CNT_W'(1);
                end
            end
            cnt_next = k;
        end else if (pop) begin
            for (int i = 0; i < SLOTS - 1; i++) begin
                slot_next[i] = slot_reg[i + 1];
            end
            cnt_next = cnt_reg - SLOT_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_char_reg    <= '0;
            take_chars_reg    <= '0;
            a_valid_reg       <= 1'b0;
            mark_phase_reg    <= PH_START;
            held_bytes_reg[0] <= 8'h00;
            held_bytes_reg[1] <= 8'h00;
            body_reg          <= '0;
            cnt_reg           <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_START_CHAR: start_char_reg <= cfg_wdata;
                    REG_TAKE_CHARS: take_chars_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_ready) begin
                a_valid_reg <= s_valid;
            end
            if (a_take) begin
                mark_phase_reg    <= mark_phase_next;
                held_bytes_reg[0] <= held_bytes_next[0];
                held_bytes_reg[1] <= held_bytes_next[1];
                body_reg          <= body_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    // hold the payload of the input register until taken
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            a_byte_reg <= s_byte_in;
            a_eos_reg  <= s_end_of_string;
        end
        for (int i = 0; i < SLOTS; i++) begin
            slot_reg[i] <= slot_next[i];
        end
    end

`ifndef ASSERT_OFF
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_string_done |-> cnt_reg == SLOT_CNT_W'(1))
        else $error("final result is not the last buffered result");

    a_halt_closes_window: assert property (@(posedge aclk) disable iff (!aresetn)
        body_reg.halted |-> !body_reg.in_window)
        else $error("window open after invalid lead byte");

    a_done_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_string_done |-> !m_byte_valid)
        else $error("final result carries a window byte");

    a_empty_takes: assert property (@(posedge aclk) disable iff (!aresetn)
        !a_valid_reg |-> s_ready)
        else $error("input stalled with empty input register");
`endif

endmodule

[dv/tb_utf8_char_window_extractor.sv]
module tb_utf8_char_window_extractor;
    timeunit 1ns;
    timeprecision 1ps;
    import ucwe_pkg::*;

    localparam int SETTLE      = 8;
    localparam int STALL_LEN   = 300;
    localparam int QUIET_LIMIT = 2000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CHAR_W-1:0]    cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_byte_in = 8'h00;
    logic                 s_end_of_string = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [7:0]           m_byte_out;
    logic                 m_byte_valid;
    logic                 m_string_done;
    logic [CHAR_W-1:0]    m_char_total;

    utf8_char_window_extractor dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_in       (s_byte_in),
        .s_end_of_string (s_end_of_string),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_byte_out      (m_byte_out),
        .m_byte_valid    (m_byte_valid),
        .m_string_done   (m_string_done),
        .m_char_total    (m_char_total)
    );

    // window predictor state
    logic [1:0]        mark_ph = PH_START;
    logic [7:0]        held_ef = 8'h00;
    logic [7:0]        held_bb = 8'h00;
    logic [2:0]        skip_n = 3'd0;
    logic              win = 1'b0;
    logic [CHAR_W-1:0] chars_seen = '0;
    logic [CHAR_W-1:0] take_n = '0;
    logic              stopped = 1'b0;
    logic [CHAR_W-1:0] reg_start = '0;
    logic [CHAR_W-1:0] reg_take = '0;

    result_t    expected_results[$];
    logic [7:0] str_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_req = 0;
    int stall_seen = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int n_words = 0;
    int n_strings = 0;
    int n_results = 0;
    int n_writes = 0;
    int n_bad = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int char_len(input logic [7:0] b);
        casez (b)
            8'b0???????: return 1;
            8'b110?????: return 2;
            8'b1110????: return 3;
            8'b11110???: return 4;
            8'b111110??: return 5;
            8'b1111110?: return 6;
            default:     return 0;
        endcase
    endfunction

    task automatic push_result(input logic [7:0] b, input logic v, input logic done);
        result_t r;
        r.byte_out    = b;
        r.byte_valid  = v;
        r.string_done = done;
        r.char_total  = chars_seen;
        expected_results.push_back(r);
    endtask

    task automatic window_byte(input logic [7:0] b);
        int len;
        len = char_len(b);
        if (!stopped) begin
            if (skip_n != 3'd0) begin
                skip_n = skip_n - 3'd1;
                if (win) push_result(b, 1'b1, 1'b0);
            end else if (len == 0) begin
                stopped = 1'b1;
                win = 1'b0;
            end else begin
                win = (chars_seen >= reg_start) && (take_n != '0);
                if (win) take_n = take_n - CHAR_W'(1);
                if (chars_seen != CHAR_MAX) chars_seen = chars_seen + CHAR_W'(1);
                skip_n = 3'(len - 1);
                if (win) push_result(b, 1'b1, 1'b0);
            end
        end
    endtask

    task automatic predict_window(input logic [7:0] b, input logic eos);
        if (mark_ph == PH_START) begin
            skip_n = 3'd0;
            win = 1'b0;
            chars_seen = '0;
            take_n = reg_take;
            stopped = 1'b0;
        end
        case (mark_ph)
            PH_START: begin
                if (b == BOM_0 && !eos) begin
                    held_ef = b;
                    mark_ph = PH_HELD_EF;
                end else begin
                    mark_ph = PH_BODY;
                    window_byte(b);
                end
            end
            PH_HELD_EF: begin
                if (b == BOM_1 && !eos) begin
                    held_bb = b;
                    mark_ph = PH_HELD_BB;
                end else begin
                    mark_ph = PH_BODY;
                    window_byte(held_ef);
                    window_byte(b);
                end
            end
            PH_HELD_BB: begin
                mark_ph = PH_BODY;
                if (b != BOM_2) begin
                    window_byte(held_ef);
                    window_byte(held_bb);
                    window_byte(b);
                end
            end
            default: window_byte(b);
        endcase
        if (eos) begin
            push_result(8'h00, 1'b0, 1'b1);
            mark_ph = PH_START;
            n_strings++;
        end
    endtask

    always @(negedge aclk) begin
        if (stall_seen != stall_req) begin
            stall_seen = stall_req;
            stall_left = STALL_LEN;
        end
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_result
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (expected_results.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result: byte %h valid %b done %b total %0d",
                             m_byte_out, m_byte_valid, m_string_done, m_char_total);
            end else begin
                want = expected_results.pop_front();
                if (m_byte_out !== want.byte_out || m_byte_valid !== want.byte_valid ||
                    m_string_done !== want.string_done ||
                    m_char_total !== want.char_total) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch: got byte %h valid %b done %b total %0d, %s",
                                 m_byte_out, m_byte_valid, m_string_done, m_char_total,
                                 $sformatf("want byte %h valid %b done %b total %0d",
                                           want.byte_out, want.byte_valid,
                                           want.string_done, want.char_total));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic eos);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_byte_in <= b;
        s_end_of_string <= eos;
        do @(posedge aclk); while (!s_ready);
        predict_window(b, eos);
        n_words++;
    endtask

    task automatic send_string();
        for (int i = 0; i < str_q.size(); i++)
            send_word(str_q[i], i == str_q.size() - 1);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CHAR_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_START_CHAR) reg_start = val;
        else if (idx == REG_TAKE_CHARS) reg_take = val;
        n_writes++;
    endtask

    function automatic logic [CHAR_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return CHAR_MAX;
        if (r == 2) return CHAR_W'($urandom);
        return CHAR_W'($urandom_range(0, 6));
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 1;
        if (r < 60) return 2;
        if (r < 75) return 3;
        if (r < 87) return 4;
        if (r < 93) return 5;
        if (r < 98) return 6;
        return 0;
    endfunction

    task automatic add_char(input int len);
        logic [7:0] lead;
        case (len)
            1:       lead = 8'($urandom_range(0, 127));
            2:       lead = 8'(8'hc0 + $urandom_range(0, 31));
            3:       lead = 8'(8'he0 + $urandom_range(0, 15));
            4:       lead = 8'(8'hf0 + $urandom_range(0, 7));
            5:       lead = 8'(8'hf8 + $urandom_range(0, 3));
            6:       lead = 8'(8'hfc + $urandom_range(0, 1));
            default: lead = $urandom_range(0, 1) ? 8'(8'h80 + $urandom_range(0, 63))
                                                 : 8'(8'hfe + $urandom_range(0, 1));
        endcase
        str_q.push_back(lead);
        for (int i = 1; i < len; i++)
            str_q.push_back($urandom_range(0, 9) == 0 ? 8'($urandom)
                                                      : 8'(8'h80 + $urandom_range(0, 63)));
    endtask

    task automatic build_string();
        int kind;
        str_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 8)) str_q.push_back(8'($urandom));
        end else if (kind < 12) begin
            str_q.push_back(BOM_0);
            if (kind >= 10) str_q.push_back(BOM_1);
        end else begin
            if (kind < 40) begin
                str_q.push_back(BOM_0);
                str_q.push_back(BOM_1);
                str_q.push_back(BOM_2);
            end else if (kind < 46) begin
                str_q.push_back(BOM_0);
            end else if (kind < 50) begin
                str_q.push_back(BOM_0);
                str_q.push_back(BOM_1);
            end
            repeat ($urandom_range(1, 10)) add_char(pick_len());
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3))
                    if (str_q.size() > 1) void'(str_q.pop_back());
            end
        end
    endtask

    task automatic test_mark_handling();
        write_reg(REG_START_CHAR, '0);
        write_reg(REG_TAKE_CHARS, CHAR_MAX);
        str_q = '{BOM_0, BOM_1, BOM_2, 8'h41};
        send_string();
        str_q = '{BOM_0};
        send_string();
        str_q = '{BOM_0, BOM_1};
        send_string();
        str_q = '{BOM_0, BOM_1, 8'h00};
        send_string();
        wait_idle();
    endtask

    task automatic test_lead_classes();
        str_q = '{8'h7f, 8'hc3, 8'ha9, 8'hf8, 8'hff, 8'h41};
        send_string();
        str_q = '{8'h80, 8'h41};
        send_string();
        str_q = '{8'hfe};
        send_string();
        wait_idle();
    endtask

    task automatic test_window_edges();
        write_reg(REG_START_CHAR, CHAR_W'(1));
        write_reg(REG_TAKE_CHARS, CHAR_W'(1));
        send_word(8'h41, 1'b0);
        send_word(8'he2, 1'b0);
        wait_idle();
        // take applies from the next string, start at once
        write_reg(REG_START_CHAR, CHAR_MAX);
        write_reg(REG_TAKE_CHARS, '0);
        send_word(8'h82, 1'b0);
        send_word(8'hac, 1'b0);
        send_word(8'h42, 1'b1);
        wait_idle();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_START_CHAR, '0);
        write_reg(REG_TAKE_CHARS, CHAR_MAX);
        stall_req++;
        repeat (3) begin
            str_q.delete();
            repeat (20) add_char(1);
            send_string();
        end
        wait_idle();
    endtask

    task automatic test_random_traffic(input int n, input int send_pct, input int recv_pct);
        int stop_at;
        stop_at = n_words + n;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (n_words < stop_at) begin
            if ($urandom_range(0, 5) == 0) begin
                wait_idle();
                write_reg(REG_START_CHAR, pick_count());
                write_reg(REG_TAKE_CHARS, pick_count());
            end
            build_string();
            send_string();
        end
        wait_idle();
    endtask

    initial begin
        send_idle_pct = 18;
        recv_idle_pct = 61;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_mark_handling();
        test_lead_classes();
        test_window_edges();
        test_random_traffic(130, 18, 61);
        test_random_traffic(130, 61, 18);
        test_backpressure();
        test_random_traffic(130, 0, 0);

        if (expected_results.size() != 0) begin
            $display("%0d expected results never arrived", expected_results.size());
            n_bad += expected_results.size();
        end
        $display("Sent %0d bytes in %0d strings over %0d register settings,",
                 n_words, n_strings, n_writes);
        $display("checked %0d results, %0d faults.", n_results, n_bad);
        if (n_bad == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[utf8_char_window_extractor.f]
rtl/core/ucwe_pkg.sv
rtl/core/utf8_char_window_extractor.sv
dv/tb_utf8_char_window_extractor.sv
